### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the line rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, muted while reset is high.
`define DDA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Types, constants and codes shared by the line rasterizer modules.
// ----------------------------------------------------------------------------
package dda_pkg;

   localparam int DDA_FRAC_BITS  = 16;   // default fraction bits of positions
   localparam int COORD_BITS     = 12;   // endpoint coordinate width (signed)
   localparam int PIX_W          = 11;   // pixel index / image size width

   localparam logic [PIX_W-1:0] IMAGE_ROWS_RST = PIX_W'(500);
   localparam logic [PIX_W-1:0] IMAGE_COLS_RST = PIX_W'(500);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic {
      CSR_IMAGE_ROWS = 1'b0,
      CSR_IMAGE_COLS = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type                        op;
      logic signed [COORD_BITS-1:0]  row_start;
      logic signed [COORD_BITS-1:0]  col_start;
      logic signed [COORD_BITS-1:0]  row_end;
      logic signed [COORD_BITS-1:0]  col_end;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_row;
      logic [PIX_W-1:0] pixel_col;
      logic             plot;
      logic             last;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch endpoints, seed divider and accumulators
      logic advance;     // step word accepted
      logic div_run;     // one quotient bit this cycle
      logic div_first;   // first quotient bit (integer bit, no shift)
      logic commit;      // write signed increments
   } dda_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_full;    // result register holds an unsent word
   } dda_status_type;

endpackage

### rtl/dda_div_lane.sv
// ----------------------------------------------------------------------------
// dda_div_lane
// Restoring divider, one quotient bit per cycle: (mag << FRAC_BITS) / divisor.
// ----------------------------------------------------------------------------
module dda_div_lane #(
   parameter int FRAC_BITS = dda_pkg::DDA_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic                              run,
   input  logic                              first,
   input  logic [dda_pkg::COORD_BITS-1:0]    dividend_mag,
   input  logic [dda_pkg::COORD_BITS-1:0]    divisor,
   output logic [FRAC_BITS:0]                quotient
);
   import dda_pkg::*;

   logic [COORD_BITS:0] rem_ff, rem_in;
   logic [FRAC_BITS:0]  quo_ff, quo_in;
   logic [COORD_BITS:0] trial;
   logic                fits;

   // rem < divisor after the first bit, so the shift never overflows
   always_comb begin
      trial  = first ? rem_ff : {rem_ff[COORD_BITS-1:0], 1'b0};
      fits   = trial >= {1'b0, divisor};
      rem_in = fits ? trial - {1'b0, divisor} : trial;
      quo_in = {quo_ff[FRAC_BITS-1:0], fits};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= {1'b0, dividend_mag};
      end else if (run) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;

endmodule

### rtl/dda_ctrl.sv
// ----------------------------------------------------------------------------
// dda_ctrl
// Sequencer: accepts words, runs the increment division, commits the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dda_ctrl #(
   parameter int FRAC_BITS = dda_pkg::DDA_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  dda_pkg::op_type         req_op,
   input  logic                    rsp_stall,
   input  dda_pkg::dda_status_type status,
   output logic                    req_stall,
   output dda_pkg::dda_cmd_type    cmd
);
   import dda_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_stall = (state_ff != ST_IDLE) || (status.out_full && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load    = accept && (req_op == OP_LOAD);
            cmd.advance = accept && (req_op == OP_STEP);
            if (cmd.load) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            cmd.div_run   = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `DDA_ASSERT(a_busy_stalls, clock, reset, (state_ff != ST_IDLE) |-> req_stall, "word taken while busy")
   `DDA_ASSERT(a_load_divides, clock, reset, cmd.load |=> (state_ff == ST_DIV && cnt_ff == '0), "load did not start division")
   `DDA_ASSERT(a_div_ends, clock, reset, (state_ff == ST_DIV && cnt_ff == CNT_LAST) |=> cmd.commit, "division did not end in commit")

endmodule

### rtl/dda_datapath.sv
// ----------------------------------------------------------------------------
// dda_datapath
// Endpoint setup, two divider lanes, DDA accumulators, bounds test, result reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dda_datapath #(
   parameter int FRAC_BITS = dda_pkg::DDA_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dda_pkg::dda_cmd_type          cmd,
   output dda_pkg::dda_status_type       status,
   input  dda_pkg::req_word_type         req_data,
   input  logic                          csr_we,
   input  dda_pkg::csr_index_type        csr_index,
   input  logic [dda_pkg::PIX_W-1:0]     csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dda_pkg::rsp_word_type         rsp_data
);
   import dda_pkg::*;

   localparam int AW = COORD_BITS + FRAC_BITS + 1;   // position
   localparam int SW = FRAC_BITS + 2;                // increment
   localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

   logic [PIX_W-1:0]         rows_ff, cols_ff;
   logic signed [AW-1:0]     row_acc_ff, col_acc_ff, row_acc_in, col_acc_in;
   logic signed [SW-1:0]     row_inc_ff, col_inc_ff;
   logic [COORD_BITS-1:0]    left_ff;
   logic [COORD_BITS-1:0]    divisor_ff;
   logic                     row_neg_ff, col_neg_ff, zero_ff;
   logic                     rsp_valid_ff;
   rsp_word_type             rsp_data_ff, rsp_data_in;

   logic signed [COORD_BITS:0] d_row, d_col;
   logic [COORD_BITS-1:0]      m_row, m_col, n_max;
   logic [FRAC_BITS:0]         q_row, q_col;
   logic [AW-1:0]              v_row, v_col;
   logic [COORD_BITS:0]        pix_row, pix_col;
   logic                       in_row, in_col, emit;

   // ---- load setup
   always_comb begin
      d_row = {req_data.row_end[COORD_BITS-1], req_data.row_end}
            - {req_data.row_start[COORD_BITS-1], req_data.row_start};
      d_col = {req_data.col_end[COORD_BITS-1], req_data.col_end}
            - {req_data.col_start[COORD_BITS-1], req_data.col_start};
      m_row = d_row[COORD_BITS] ? COORD_BITS'(-d_row) : d_row[COORD_BITS-1:0];
      m_col = d_col[COORD_BITS] ? COORD_BITS'(-d_col) : d_col[COORD_BITS-1:0];
      n_max = (m_row > m_col) ? m_row : m_col;
   end

   dda_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_row (
      .clock(clock), .load(cmd.load), .run(cmd.div_run), .first(cmd.div_first),
      .dividend_mag(m_row), .divisor(divisor_ff), .quotient(q_row)
   );

   dda_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_col (
      .clock(clock), .load(cmd.load), .run(cmd.div_run), .first(cmd.div_first),
      .dividend_mag(m_col), .divisor(divisor_ff), .quotient(q_col)
   );

   // ---- step: advance, round, bounds test
   always_comb begin
      row_acc_in = row_acc_ff + {{(AW-SW){row_inc_ff[SW-1]}}, row_inc_ff};
      col_acc_in = col_acc_ff + {{(AW-SW){col_inc_ff[SW-1]}}, col_inc_ff};
      v_row      = row_acc_in + HALF;
      v_col      = col_acc_in + HALF;
      pix_row    = v_row[AW-1:FRAC_BITS];       // floor via arithmetic shift
      pix_col    = v_col[AW-1:FRAC_BITS];
      in_row     = !pix_row[COORD_BITS] &&
                   (pix_row[COORD_BITS-1:0] < {{(COORD_BITS-PIX_W){1'b0}}, rows_ff});
      in_col     = !pix_col[COORD_BITS] &&
                   (pix_col[COORD_BITS-1:0] < {{(COORD_BITS-PIX_W){1'b0}}, cols_ff});
      rsp_data_in.plot      = in_row && in_col;
      rsp_data_in.pixel_row = rsp_data_in.plot ? pix_row[PIX_W-1:0] : '0;
      rsp_data_in.pixel_col = rsp_data_in.plot ? pix_col[PIX_W-1:0] : '0;
      rsp_data_in.last      = (left_ff == COORD_BITS'(1));
      emit       = cmd.advance && (left_ff != '0);
   end

   // ---- control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= IMAGE_ROWS_RST;
         cols_ff      <= IMAGE_COLS_RST;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_IMAGE_ROWS: rows_ff <= csr_wdata;
               CSR_IMAGE_COLS: cols_ff <= csr_wdata;
               default:        rows_ff <= rows_ff;
            endcase
         end
         if (cmd.load) begin
            left_ff <= n_max;
         end else if (emit) begin
            left_ff <= left_ff - 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_acc_ff <= {req_data.row_start[COORD_BITS-1], req_data.row_start,
                        {FRAC_BITS{1'b0}}};
         col_acc_ff <= {req_data.col_start[COORD_BITS-1], req_data.col_start,
                        {FRAC_BITS{1'b0}}};
         divisor_ff <= n_max;
         row_neg_ff <= d_row[COORD_BITS];
         col_neg_ff <= d_col[COORD_BITS];
         zero_ff    <= (n_max == '0);
      end else if (emit) begin
         row_acc_ff <= row_acc_in;
         col_acc_ff <= col_acc_in;
      end
      if (cmd.commit) begin
         row_inc_ff <= zero_ff ? '0 : (row_neg_ff ? -{1'b0, q_row} : {1'b0, q_row});
         col_inc_ff <= zero_ff ? '0 : (col_neg_ff ? -{1'b0, q_col} : {1'b0, q_col});
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.out_full = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   `DDA_ASSERT(a_idle_step_silent, clock, reset, (cmd.advance && left_ff == '0 && !rsp_valid_ff) |=> !rsp_valid_ff, "word produced with no line pending")
   `DDA_ASSERT(a_step_counts, clock, reset, emit |=> (left_ff == $past(left_ff) - 1'b1), "step count not decremented")
   `DDA_ASSERT(a_last_ends_line, clock, reset, (emit && rsp_data_in.last) |=> (left_ff == '0), "last word left steps pending")

endmodule

### rtl/dda_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line generator: load endpoints, then emit one rounded pixel per step while steps remain.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake             word
//   req_     in   req_valid/req_stall   op, row/col start, row/col end
//   rsp_     out  rsp_valid/rsp_stall   pixel_row, pixel_col, plot, last
//   csr_     in   csr_we                csr_index, csr_wdata (11 bits)
//
// Flow: step words can follow back to back while rsp_ drains. After a load word,
//   no word is taken until the increments are done: they come from a restoring
//   divider, one bit per cycle, and are then committed.
// Reset: synchronous; image size returns to 500 x 500, no line pending.
// Stalls: rsp_ has a one-word output register; req_ stalls while it is full
//   and stalled, and while a load is being divided and committed.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit #(
   parameter int FRAC_BITS = dda_pkg::DDA_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   // request words
   input  logic                       req_valid,
   output logic                       req_stall,
   input  dda_pkg::req_word_type      req_data,
   // result words
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output dda_pkg::rsp_word_type      rsp_data,
   // register writes
   input  logic                       csr_we,
   input  dda_pkg::csr_index_type     csr_index,
   input  logic [dda_pkg::PIX_W-1:0]  csr_wdata
);
   import dda_pkg::*;

   dda_cmd_type    cmd;
   dda_status_type status;

   // sequencer: word acceptance and divide sequencing
   dda_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // datapath: setup, dividers, accumulators, result register
   dda_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dda_line_rasterizer_unit. A directed table covers
// reset state, extreme endpoints, zero-length and abandoned lines, steps with
// no line pending and the image edge. Random lines follow under several image
// sizes and handshake mixes. Each result word is checked against the table's typed
// pixel or, for all others, a fixed-point line tracer kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
   import dda_pkg::*;

   localparam int FRAC_BITS       = DDA_FRAC_BITS;
   // a load holds the block while its increments are divided; settle well past that
   localparam int SETTLE_CYCLES   = FRAC_BITS + 16;
   localparam int QUIET_LIMIT     = 4000;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 156;
   localparam int PICK_RANDOM     = -1;
   localparam int COORD_MIN       = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX       = (1 << (COORD_BITS - 1)) - 1;
   localparam int REQ_W           = $bits(req_word_type);

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mix_type;

   // one row of the directed table; pixel is used only where typed is set
   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type pixel;
   } vector_type;

   localparam rsp_word_type NO_PIXEL = '0;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_word_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_word_type         rsp_data;
   logic                 csr_we    = 1'b0;
   csr_index_type        csr_index = CSR_IMAGE_ROWS;
   logic [PIX_W-1:0]     csr_wdata = '0;

   // line tracer state: positions and increments in FRAC_BITS fixed point
   longint               row_pos, col_pos, row_inc, col_inc;
   int                   steps_to_go;
   logic [PIX_W-1:0]     rows_limit, cols_limit;

   rsp_word_type         pixel_queue[$];
   vector_type           directed[$];

   int                   sender_pct;
   int                   stall_pct;
   int                   error_count;
   int                   lines_loaded;
   int                   pixels_seen;
   int                   pixels_plotted;
   int                   quiet_cycles;

   dda_line_rasterizer_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Word builders
   // ------------------------------------------------------------------------
   function automatic logic signed [COORD_BITS-1:0] fit_coord(input int v);
      if (v < COORD_MIN) v = COORD_MIN;
      if (v > COORD_MAX) v = COORD_MAX;
      return COORD_BITS'(v);
   endfunction

   function automatic req_word_type load_w(input int r0, input int c0,
                                           input int r1, input int c1);
      req_word_type w;
      w.op        = OP_LOAD;
      w.row_start = fit_coord(r0);
      w.col_start = fit_coord(c0);
      w.row_end   = fit_coord(r1);
      w.col_end   = fit_coord(c1);
      return w;
   endfunction

   // endpoints of a step word are don't-care; fill them with noise
   function automatic req_word_type step_w();
      req_word_type w;
      w           = req_word_type'(REQ_W'({$urandom, $urandom}));
      w.op        = OP_STEP;
      return w;
   endfunction

   function automatic rsp_word_type pix(input int r, input int c,
                                        input bit plot, input bit last);
      rsp_word_type p;
      p.pixel_row = PIX_W'(r);
      p.pixel_col = PIX_W'(c);
      p.plot      = plot;
      p.last      = last;
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // Line tracer
   // ------------------------------------------------------------------------
   // d / n in fixed point, quotient truncated toward zero
   function automatic longint fixed_ratio(input longint d, input longint n);
      longint q;
      q = ((d < 0 ? -d : d) <<< FRAC_BITS) / n;
      return d < 0 ? -q : q;
   endfunction

   // Applies one accepted word; returns 1 when it yields a pixel word.
   function automatic bit trace_line(input req_word_type w, output rsp_word_type px);
      longint r0, c0, dr, dc, n, pr, pc;
      bit     in_image;
      px = '0;
      if (w.op == OP_LOAD) begin
         r0 = $signed(w.row_start);
         c0 = $signed(w.col_start);
         dr = longint'($signed(w.row_end)) - r0;
         dc = longint'($signed(w.col_end)) - c0;
         n  = (dr < 0 ? -dr : dr);
         if ((dc < 0 ? -dc : dc) > n) n = (dc < 0 ? -dc : dc);
         row_pos     = r0 <<< FRAC_BITS;
         col_pos     = c0 <<< FRAC_BITS;
         steps_to_go = int'(n);
         row_inc     = (n != 0) ? fixed_ratio(dr, n) : 0;
         col_inc     = (n != 0) ? fixed_ratio(dc, n) : 0;
         return 1'b0;
      end
      if (steps_to_go == 0) return 1'b0;
      row_pos     += row_inc;
      col_pos     += col_inc;
      steps_to_go -= 1;
      // round half up: add 0.5, then floor
      pr = (row_pos + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      pc = (col_pos + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      in_image = pr >= 0 && pc >= 0 &&
                 pr < longint'(rows_limit) && pc < longint'(cols_limit);
      px.pixel_row = in_image ? pr[PIX_W-1:0] : '0;
      px.pixel_col = in_image ? pc[PIX_W-1:0] : '0;
      px.plot      = in_image;
      px.last      = (steps_to_go == 0);
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------
   task automatic send_word(input req_word_type w, input bit typed,
                            input rsp_word_type typed_px, output bit emitted);
      rsp_word_type px;
      while ($urandom_range(99) < sender_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      emitted = trace_line(w, px);
      if (emitted) pixel_queue.push_back(typed ? typed_px : px);
      if (w.op == OP_LOAD) lines_loaded++;
   endtask

   // sender goes quiet until every pixel word owed has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixel_queue.size() != 0);
   endtask

   task automatic set_image_size(input int rows, input int cols);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_ROWS;
      csr_wdata <= PIX_W'(rows);
      @(posedge clock);
      rows_limit = PIX_W'(rows);
      csr_index <= CSR_IMAGE_COLS;
      csr_wdata <= PIX_W'(cols);
      @(posedge clock);
      cols_limit = PIX_W'(cols);
      csr_we    <= 1'b0;
   endtask

   task automatic set_idle_mix(input idle_mix_type mix);
      sender_pct = (mix == IDLE_SENDER)   ? 69 : (mix == IDLE_BOTH) ? 14 : 0;
      stall_pct  = (mix == IDLE_RECEIVER) ? 69 : (mix == IDLE_BOTH) ? 14 : 0;
   endtask

   // pick a line origin: image corner, far image edge, or anywhere
   function automatic int pick_base(input logic [PIX_W-1:0] limit);
      case ($urandom_range(3))
         0:       return 0;
         1:       return int'(limit);
         default: return $urandom_range(0, 2047);
      endcase
   endfunction

   // Random lines. Mostly short lines at an image edge or anywhere, run to the end;
   // some are cut short by the next load, some get extra idle steps, and a
   // few span the full coordinate range. Only loads and pixel-producing
   // steps count against the budget.
   task automatic run_lines(input int word_budget);
      int           counted, kind, shape, br, bc, issued, i;
      bit           emitted;
      req_word_type w;
      counted = 0;
      while (counted < word_budget) begin
         if ($urandom_range(99) < 3) hold_until_drained();
         kind = $urandom_range(99);
         if (kind < 15) begin
            w = load_w($urandom_range(0, 4095) + COORD_MIN, $urandom_range(0, 4095) + COORD_MIN,
                       $urandom_range(0, 4095) + COORD_MIN, $urandom_range(0, 4095) + COORD_MIN);
         end else begin
            br = pick_base(rows_limit);
            bc = pick_base(cols_limit);
            w  = load_w(br + $urandom_range(0, 24) - 12, bc + $urandom_range(0, 24) - 12,
                        br + $urandom_range(0, 24) - 12, bc + $urandom_range(0, 24) - 12);
         end
         send_word(w, 1'b0, NO_PIXEL, emitted);
         counted++;
         shape = $urandom_range(99);
         if (kind < 15)
            issued = (steps_to_go < 8) ? steps_to_go : $urandom_range(1, 8);
         else if (shape < 80)
            issued = steps_to_go;
         else if (shape < 90)
            issued = steps_to_go + $urandom_range(1, 2);
         else
            issued = (steps_to_go == 0) ? 0 : $urandom_range(0, steps_to_go - 1);
         for (i = 0; i < issued; i++) begin
            send_word(step_w(), 1'b0, NO_PIXEL, emitted);
            if (emitted) counted++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            $display("%0t: pixel word with none owed, got %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pixel_queue.pop_front();
            compare_field("pixel_row", want.pixel_row, rsp_data.pixel_row);
            compare_field("pixel_col", want.pixel_col, rsp_data.pixel_col);
            compare_field("plot",      want.plot,      rsp_data.plot);
            compare_field("last",      want.last,      rsp_data.last);
            pixels_seen++;
            if (want.plot) pixels_plotted++;
         end
      end
   end

   // watchdog: no handshake on either channel for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no handshake in %0d cycles, %0d words owed",
                  $time, QUIET_LIMIT, pixel_queue.size());
         $display("dda_line_rasterizer_unit regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   int rows_plan[RANDOM_PHASES] = '{2047, 1, 0, 2047, PICK_RANDOM, 640, PICK_RANDOM, 500};
   int cols_plan[RANDOM_PHASES] = '{2047, 1, 2047, 0, PICK_RANDOM, 480, PICK_RANDOM, 500};

   initial begin
      bit emitted;
      int rows, cols;
      error_count    = 0;
      lines_loaded   = 0;
      pixels_seen    = 0;
      pixels_plotted = 0;
      quiet_cycles   = 0;
      steps_to_go    = 0;
      row_pos        = 0;
      col_pos        = 0;
      row_inc        = 0;
      col_inc        = 0;
      rows_limit     = IMAGE_ROWS_RST;
      cols_limit     = IMAGE_COLS_RST;
      set_idle_mix(IDLE_NONE);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, 500 x 500 image from reset. Typed rows are read
      // straight off the line geometry; the rest go through the tracer.
      directed = '{
         '{step_w(),                                  1'b0, NO_PIXEL},           // nothing pending
         '{load_w(0, 0, 3, 0),                        1'b0, NO_PIXEL},
         '{step_w(),                                  1'b1, pix(1, 0, 1, 0)},
         '{step_w(),                                  1'b1, pix(2, 0, 1, 0)},
         '{step_w(),                                  1'b1, pix(3, 0, 1, 1)},
         '{step_w(),                                  1'b0, NO_PIXEL},           // line done
         '{load_w(5, 5, 5, 5),                        1'b0, NO_PIXEL},           // zero length
         '{step_w(),                                  1'b0, NO_PIXEL},
         '{load_w(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX), 1'b0, NO_PIXEL},
         '{step_w(),                                  1'b1, pix(0, 0, 0, 0)},    // -2047: off image
         '{load_w(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN), 1'b0, NO_PIXEL}, // drops prior line
         '{step_w(),                                  1'b1, pix(0, 0, 0, 0)},    // 2046: off image
         '{load_w(0, 0, 1, 2),                        1'b0, NO_PIXEL},
         '{step_w(),                                  1'b1, pix(1, 1, 1, 0)},    // 0.5 rounds up
         '{step_w(),                                  1'b1, pix(1, 2, 1, 1)},
         '{load_w(498, 0, 500, 0),                    1'b0, NO_PIXEL},
         '{step_w(),                                  1'b1, pix(499, 0, 1, 0)},
         '{step_w(),                                  1'b1, pix(0, 0, 0, 1)},    // row 500 is out
         '{load_w(0, 1, 0, -1),                       1'b0, NO_PIXEL},
         '{step_w(),                                  1'b1, pix(0, 0, 1, 0)},
         '{step_w(),                                  1'b1, pix(0, 0, 0, 1)},    // col -1 is out
         '{load_w(0, 0, -1, -2),                      1'b0, NO_PIXEL},
         '{step_w(),                                  1'b0, NO_PIXEL},
         '{step_w(),                                  1'b0, NO_PIXEL},
         '{load_w(10, 10, 7, 3),                      1'b0, NO_PIXEL},
         '{step_w(),                                  1'b0, NO_PIXEL}            // cut off below
      };
      foreach (directed[i])
         send_word(directed[i].word, directed[i].typed, directed[i].pixel, emitted);

      // Random phases: new image size and handshake mix each time, written
      // only once the block has gone idle.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         hold_until_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         rows = (rows_plan[phase] == PICK_RANDOM) ? $urandom_range(1, 2047) : rows_plan[phase];
         cols = (cols_plan[phase] == PICK_RANDOM) ? $urandom_range(1, 2047) : cols_plan[phase];
         set_image_size(rows, cols);
         set_idle_mix(idle_mix_type'(phase % 4));
         run_lines(WORDS_PER_PHASE);
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d lines over %0d image sizes, idle mixes from none to 69%% either side",
               lines_loaded, RANDOM_PHASES + 1);
      $display("checked %0d pixel words, %0d of them plotted, %0d errors",
               pixels_seen, pixels_plotted, error_count);
      if (error_count == 0)
         $display("dda_line_rasterizer_unit regression: pass");
      else
         $display("dda_line_rasterizer_unit regression: fail");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/dda_pkg.sv
rtl/dda_div_lane.sv
rtl/dda_ctrl.sv
rtl/dda_datapath.sv
rtl/dda_line_rasterizer_unit.sv
sim/testbench.sv
